// ----- src/bgc_pkg.sv -----
// Package for the button gesture classifier: codes, reset values and shared types.
`timescale 1ns / 1ps
package bgc_pkg;

	// default sizing
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int TIMER_BITS_DEF  = 16;

	// register field width and APB sizing
	localparam int REG_W   = 16;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 5;

	// register indexes (word address = paddr[4:2])
	localparam logic [2:0] REG_CLICK_MIN      = 3'd0;
	localparam logic [2:0] REG_LONG_CLICK_MIN = 3'd1;
	localparam logic [2:0] REG_HOLD_MIN       = 3'd2;
	localparam logic [2:0] REG_LONG_HOLD_MIN  = 3'd3;
	localparam logic [2:0] REG_IDLE_GAP       = 3'd4;

	// register reset values
	localparam logic [REG_W-1:0] CLICK_MIN_RST      = 16'd250;
	localparam logic [REG_W-1:0] LONG_CLICK_MIN_RST = 16'd1000;
	localparam logic [REG_W-1:0] HOLD_MIN_RST       = 16'd3000;
	localparam logic [REG_W-1:0] LONG_HOLD_MIN_RST  = 16'd5000;
	localparam logic [REG_W-1:0] IDLE_GAP_RST       = 16'd1000;

	// gesture codes
	localparam logic [1:0] KIND_CLICK      = 2'd0;
	localparam logic [1:0] KIND_LONG_CLICK = 2'd1;
	localparam logic [1:0] KIND_HOLD       = 2'd2;
	localparam logic [1:0] KIND_LONG_HOLD  = 2'd3;

	// threshold registers
	typedef struct packed {
		logic [REG_W-1:0] click_min;
		logic [REG_W-1:0] long_click_min;
		logic [REG_W-1:0] hold_min;
		logic [REG_W-1:0] long_hold_min;
		logic [REG_W-1:0] idle_gap;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic tick;  // take the input word
		logic load;  // load the output register from the queue read
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic drain;     // this tick opens a drain
		logic has_items; // queue holds entries after this tick
		logic last;      // read pointer is on the final entry
		logic out_free;  // output register can take a word this cycle
	} sts_t;

endpackage

// ----- src/bgc_ram.sv -----
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module bgc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/bgc_ctrl.sv -----
// Controller FSM: accepts ticks and sequences the queue drain.
`timescale 1ns / 1ps
module bgc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bgc_pkg::sts_t sts,
	output bgc_pkg::cmd_t cmd
);
	import bgc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.tick = 1'b1;
					if (sts.drain && sts.has_items) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				// read data lands in the RAM output register
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = sts.last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/bgc_dp.sv -----
// Datapath: run timer, press classifier, gesture queue, flags and output register.
`timescale 1ns / 1ps
module bgc_dp #(
	parameter int QUEUE_DEPTH = bgc_pkg::QUEUE_DEPTH_DEF,
	parameter int TIMER_BITS  = bgc_pkg::TIMER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bgc_pkg::cfg_t cfg,
	input  bgc_pkg::cmd_t cmd,
	output bgc_pkg::sts_t sts,
	input  logic          button_level,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    request_kind,
	output logic          armed_now,
	output logic          shutdown_latched,
	output logic          last_of_burst
);
	import bgc_pkg::*;

	localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW  = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	logic                  held_q;
	logic [TIMER_BITS-1:0] run_q;
	logic                  pending_q;
	logic [CNW-1:0]        count_q;
	logic [CNW-1:0]        idx_q;
	logic                  armed_q;
	logic                  shutdown_q;

	logic [TIMER_BITS-1:0] run_inc;
	logic [TIMER_BITS-1:0] run_new;
	logic [CW-1:0]         len_x;
	logic                  change;
	logic                  kind_ok;
	logic [1:0]            kind;
	logic                  do_enq;
	logic [CNW-1:0]        count_new;
	logic                  pending_new;
	logic [1:0]            rd_kind;
	logic                  armed_n;
	logic                  shutdown_n;

	// saturating run timer
	assign run_inc = (run_q == TIMER_MAX) ? run_q : run_q + 1'b1;
	assign change  = button_level != held_q;
	assign run_new = change ? '0 : run_inc;
	assign len_x   = CW'(run_inc);

	// classify the ending press, long hold first
	always_comb begin
		kind_ok = 1'b1;
		kind    = KIND_CLICK;
		if (len_x >= CW'(cfg.long_hold_min)) begin
			kind = KIND_LONG_HOLD;
		end else if (len_x >= CW'(cfg.hold_min)) begin
			kind = KIND_HOLD;
		end else if (len_x >= CW'(cfg.long_click_min)) begin
			kind = KIND_LONG_CLICK;
		end else if (len_x < CW'(cfg.click_min)) begin
			kind_ok = 1'b0;
		end
	end

	assign do_enq      = change && held_q && kind_ok && (count_q < CNW'(QUEUE_DEPTH));
	assign count_new   = count_q + CNW'(do_enq);
	assign pending_new = pending_q | change;

	// status for the controller
	assign sts.drain     = pending_new && !button_level &&
	                       (CW'(run_new) >= CW'(cfg.idle_gap));
	assign sts.has_items = count_new != '0;
	assign sts.last      = idx_q == (count_q - 1'b1);
	assign sts.out_free  = !out_valid || !out_stall;

	// gesture queue
	bgc_ram #(
		.WIDTH(2),
		.DEPTH(QUEUE_DEPTH),
		.AW   (AW)
	) u_queue (
		.clk  (clk),
		.we   (cmd.tick && do_enq),
		.waddr(count_q[AW-1:0]),
		.wdata(kind),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_kind)
	);

	// flags after applying the entry being loaded
	assign armed_n    = armed_q ^ (rd_kind == KIND_HOLD);
	assign shutdown_n = shutdown_q | (rd_kind == KIND_LONG_HOLD);

	// tick state, queue pointers and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 1'b0;
			run_q      <= '0;
			pending_q  <= 1'b0;
			count_q    <= '0;
			idx_q      <= '0;
			armed_q    <= 1'b0;
			shutdown_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				held_q    <= button_level;
				run_q     <= run_new;
				count_q   <= count_new;
				pending_q <= sts.drain ? 1'b0 : pending_new;
			end
			if (cmd.load) begin
				armed_q    <= armed_n;
				shutdown_q <= shutdown_n;
				if (sts.last) begin
					idx_q   <= '0;
					count_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			request_kind     <= rd_kind;
			armed_now        <= armed_n;
			shutdown_latched <= shutdown_n;
			last_of_burst    <= sts.last;
		end
	end

endmodule

// ----- src/button_gesture_classifier_core.sv -----
// Top level of the button gesture classifier: APB registers, controller and datapath.
`timescale 1ns / 1ps
// Takes one button level word per tick on the input channel and times each level run
// with a TIMER_BITS saturating counter. Releases are classified as long hold, hold,
// long click or click against the threshold registers (too-short presses dropped) and
// queued, up to QUEUE_DEPTH entries. Once the button has stayed released for idle_gap
// ticks after a level change, the queue is emitted in order on the output channel,
// the final word carrying last_of_burst. An input word that opens no drain is not
// stalled; a drain moves each entry through a RAM read, then an output register load,
// waits while the output side stalls and accepts no input. Registers sit at byte
// addresses 0, 4, 8, 12, 16; write them only while idle, the block does not check.
module button_gesture_classifier_core #(
	parameter int QUEUE_DEPTH = bgc_pkg::QUEUE_DEPTH_DEF,
	parameter int TIMER_BITS  = bgc_pkg::TIMER_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bgc_pkg::APB_AW-1:0] paddr,
	input  logic [bgc_pkg::APB_DW-1:0] pwdata,
	output logic [bgc_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       button_level,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 request_kind,
	output logic                       armed_now,
	output logic                       shutdown_latched,
	output logic                       last_of_burst
);
	import bgc_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_min      <= CLICK_MIN_RST;
			cfg_q.long_click_min <= LONG_CLICK_MIN_RST;
			cfg_q.hold_min       <= HOLD_MIN_RST;
			cfg_q.long_hold_min  <= LONG_HOLD_MIN_RST;
			cfg_q.idle_gap       <= IDLE_GAP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CLICK_MIN:      cfg_q.click_min      <= pwdata[REG_W-1:0];
				REG_LONG_CLICK_MIN: cfg_q.long_click_min <= pwdata[REG_W-1:0];
				REG_HOLD_MIN:       cfg_q.hold_min       <= pwdata[REG_W-1:0];
				REG_LONG_HOLD_MIN:  cfg_q.long_hold_min  <= pwdata[REG_W-1:0];
				REG_IDLE_GAP:       cfg_q.idle_gap       <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		case (reg_idx)
			REG_CLICK_MIN:      prdata = APB_DW'(cfg_q.click_min);
			REG_LONG_CLICK_MIN: prdata = APB_DW'(cfg_q.long_click_min);
			REG_HOLD_MIN:       prdata = APB_DW'(cfg_q.hold_min);
			REG_LONG_HOLD_MIN:  prdata = APB_DW'(cfg_q.long_hold_min);
			REG_IDLE_GAP:       prdata = APB_DW'(cfg_q.idle_gap);
			default:            prdata = '0;
		endcase
	end

	bgc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	bgc_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIMER_BITS (TIMER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.sts             (sts),
		.button_level    (button_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.request_kind    (request_kind),
		.armed_now       (armed_now),
		.shutdown_latched(shutdown_latched),
		.last_of_burst   (last_of_burst)
	);

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the button gesture classifier: stimulus, prediction and checks.
`timescale 1ns / 1ps
module testbench;
	import bgc_pkg::*;

	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         QD          = QUEUE_DEPTH_DEF;
	localparam int         DRAIN_WAIT  = 2 * QD + 8;
	// address past the last register, writes there must change nothing
	localparam logic [2:0] REG_SPARE   = 3'd5;

	// one output word as the bench sees it
	typedef struct packed {
		logic [1:0] kind;
		logic       armed;
		logic       shut;
		logic       last;
	} gesture_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                button_level = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          request_kind;
	logic                armed_now;
	logic                shutdown_latched;
	logic                last_of_burst;

	button_gesture_classifier_core u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .button_level(button_level),
		.out_valid(out_valid), .out_stall(out_stall), .request_kind(request_kind),
		.armed_now(armed_now), .shutdown_latched(shutdown_latched),
		.last_of_burst(last_of_burst)
	);

	// pending button levels and expected gesture words
	logic          tick_fifo[$];
	gesture_word_t gesture_expect[$];

	int snd_idle_pct = 31;
	int rcv_idle_pct = 45;
	int errors = 0;
	int ticks_queued = 0;
	int cycles = 0;
	bit in_acc = 1'b0;

	// predictor copy of the threshold registers
	logic [REG_W-1:0] thr_click      = CLICK_MIN_RST;
	logic [REG_W-1:0] thr_long_click = LONG_CLICK_MIN_RST;
	logic [REG_W-1:0] thr_hold       = HOLD_MIN_RST;
	logic [REG_W-1:0] thr_long_hold  = LONG_HOLD_MIN_RST;
	logic [REG_W-1:0] thr_idle_gap   = IDLE_GAP_RST;

	// predictor copy of the classifier state
	logic                      held_lvl = 1'b0;
	logic [TIMER_BITS_DEF-1:0] run_cnt = '0;
	logic                      pend = 1'b0;
	logic [1:0]                gq[QD];
	int                        qcnt = 0;
	logic                      armed_st = 1'b0;
	logic                      shut_st = 1'b0;

	// one tick: time the run, classify a finished press, drain when idle long enough
	task automatic classify_tick(input logic lvl);
		logic [1:0]    k;
		logic          keep;
		gesture_word_t w;
		if (run_cnt != '1)
			run_cnt = run_cnt + 1'b1;
		if (lvl != held_lvl) begin
			if (held_lvl) begin
				keep = 1'b1;
				k = KIND_CLICK;
				if (run_cnt >= thr_long_hold)
					k = KIND_LONG_HOLD;
				else if (run_cnt >= thr_hold)
					k = KIND_HOLD;
				else if (run_cnt >= thr_long_click)
					k = KIND_LONG_CLICK;
				else if (run_cnt < thr_click)
					keep = 1'b0;
				// full queue drops the press
				if (keep && qcnt < QD) begin
					gq[qcnt] = k;
					qcnt++;
				end
			end
			pend = 1'b1;
			held_lvl = lvl;
			run_cnt = '0;
		end
		if (pend && !held_lvl && run_cnt >= thr_idle_gap) begin
			for (int i = 0; i < qcnt; i++) begin
				if (gq[i] == KIND_HOLD)
					armed_st = ~armed_st;
				else if (gq[i] == KIND_LONG_HOLD)
					shut_st = 1'b1;
				w.kind = gq[i];
				w.armed = armed_st;
				w.shut = shut_st;
				w.last = (i == qcnt - 1);
				gesture_expect = {gesture_expect, w};
			end
			qcnt = 0;
			pend = 1'b0;
		end
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// input driver: next level word on the falling edge once the last one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_acc) begin
			in_acc = 1'b0;
			if (tick_fifo.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				button_level <= tick_fifo.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < rcv_idle_pct);
	end

	// monitor: check taken output words, predict from taken input words
	always @(posedge clk) begin : mon
		gesture_word_t exp_w;
		gesture_word_t got_w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got_w = {request_kind, armed_now, shutdown_latched, last_of_burst};
				if (gesture_expect.size() == 0) begin
					errors++;
					$display("%0t: unexpected word kind=%0d armed=%0b shut=%0b last=%0b",
						$time, got_w.kind, got_w.armed, got_w.shut, got_w.last);
				end else begin
					exp_w = gesture_expect.pop_front();
					if (got_w !== exp_w) begin
						errors++;
						$display("%0t: mismatch expected kind=%0d armed=%0b shut=%0b last=%0b, %s",
							$time, exp_w.kind, exp_w.armed, exp_w.shut, exp_w.last,
							$sformatf("actual kind=%0d armed=%0b shut=%0b last=%0b",
								got_w.kind, got_w.armed, got_w.shut, got_w.last));
					end
				end
			end
			if (in_valid && !in_stall) begin
				in_acc = 1'b1;
				classify_tick(button_level);
			end
		end
	end

	// register write: setup then access phase
	task automatic apb_write(input logic [2:0] idx, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_CLICK_MIN:      thr_click = data[REG_W-1:0];
			REG_LONG_CLICK_MIN: thr_long_click = data[REG_W-1:0];
			REG_HOLD_MIN:       thr_hold = data[REG_W-1:0];
			REG_LONG_HOLD_MIN:  thr_long_hold = data[REG_W-1:0];
			REG_IDLE_GAP:       thr_idle_gap = data[REG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// all five registers, junk in the upper half of each word
	task automatic set_thresholds(input logic [15:0] c, input logic [15:0] lc,
		input logic [15:0] h, input logic [15:0] lh, input logic [15:0] ig);
		apb_write(REG_CLICK_MIN, {16'($urandom), c});
		apb_write(REG_LONG_CLICK_MIN, {16'($urandom), lc});
		apb_write(REG_HOLD_MIN, {16'($urandom), h});
		apb_write(REG_LONG_HOLD_MIN, {16'($urandom), lh});
		apb_write(REG_IDLE_GAP, {16'($urandom), ig});
	endtask

	// wait until every word is out and the block has had time to finish a drain
	task automatic settle();
		while (tick_fifo.size() != 0 || in_valid || gesture_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic push_level(input logic lvl, input int n);
		repeat (n) tick_fifo = {tick_fifo, lvl};
		ticks_queued += n;
	endtask

	// press length near one of the thresholds, or anywhere short
	function automatic int pick_len();
		int len;
		case ($urandom_range(4))
			0: len = thr_click;
			1: len = thr_long_click;
			2: len = thr_hold;
			3: len = thr_long_hold;
			default: len = $urandom_range(1, 16);
		endcase
		len = len + int'($urandom_range(2)) - 1;
		if (len < 1)
			len = 1;
		if (len > 40)
			len = 40;
		return len;
	endfunction

	// a run of presses, mostly closed by a full idle gap, now and then with noise
	task automatic queue_burst();
		int presses;
		presses = $urandom_range(1, 10);
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(1, 8)) push_level(1'($urandom_range(1)), 1);
		for (int p = 0; p < presses; p++) begin
			push_level(1'b1, pick_len());
			push_level(1'b0, $urandom_range(1, 2));
		end
		if ($urandom_range(99) < 85)
			push_level(1'b0, int'(thr_idle_gap) + int'($urandom_range(2)));
	endtask

	task automatic random_phase(input int n_items);
		int first_tick;
		first_tick = ticks_queued;
		while (ticks_queued - first_tick < n_items)
			queue_burst();
		settle();
		// close any burst left open so the next settings start idle
		push_level(1'b0, int'(thr_idle_gap) + 1);
		settle();
	endtask

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// short thresholds: one press of each kind plus one too short
		set_thresholds(16'd2, 16'd4, 16'd7, 16'd10, 16'd3);
		apb_write(REG_SPARE, $urandom);
		push_level(1'b1, 1);
		push_level(1'b0, 1);
		push_level(1'b1, 2);
		push_level(1'b0, 1);
		push_level(1'b1, 4);
		push_level(1'b0, 1);
		push_level(1'b1, 7);
		push_level(1'b0, 1);
		push_level(1'b1, 10);
		push_level(1'b0, 3);
		settle();
		random_phase(10);

		// swapped idling; zero click and gap, thresholds out of order
		snd_idle_pct = 45;
		rcv_idle_pct = 31;
		set_thresholds(16'd0, 16'd9, 16'd3, 16'd6, 16'd0);
		random_phase(10);
		set_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		random_phase(10);

		// no idling
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_thresholds(16'd3, 16'd5, 16'd8, 16'd12, 16'd2);
		random_phase(10);

		if (errors == 0 && gesture_expect.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
